// File: rtl/cbe_pkg.sv
// ============================================================================
// Cubic Bezier evaluator package
// Shared constants for the cubic Bezier evaluator: default formats, the
// register map of the configuration port and the number of axes.
// ============================================================================
`default_nettype none

package cbe_pkg;

  // Default coordinate width (signed Q8.8) and parameter fraction width.
  localparam int COORD_BITS_DEF      = 16;
  localparam int PARAM_FRAC_BITS_DEF = 15;

  // Four control points, three axes each.
  localparam int NUM_CTRL = 4;
  localparam int NUM_AXES = 3;

  // Configuration port: 64-bit data, registers at byte address 8*i.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = $clog2(NUM_CTRL);
  localparam int CFG_ADDR_W = CFG_IDX_W + 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_POINT_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_POINT_1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_POINT_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_POINT_3 = CFG_IDX_W'(3);

endpackage : cbe_pkg

`default_nettype wire

// File: rtl/cubic_bezier_evaluator.sv
// ============================================================================
// Cubic Bezier evaluator
// Evaluates a 3D cubic Bezier curve, its first and its second derivative at
// a streamed parameter t, in exact fixed point with one final rounding.
// ============================================================================
// The block takes one t per clock on the slave stream and returns one result
// per clock on the master stream unless stalled; each transaction passes
// seven register stages (input register, five arithmetic stages, output
// register). The four control points are written through the APB port; from
// them the block keeps power-basis coefficients in registers that follow the
// control points in the next clock, so a write should precede the next input
// transaction by at least one clock. The curve is evaluated by Horner's rule
// in t, multiply and add stages alternating; the last multiplication, on the
// widest value, is split into two partial products that are summed in the
// output stage. A t above 1.0 is treated as exactly 1.0. Results are rounded
// to nearest with ties toward plus infinity. A stall on the master side
// holds the whole pipeline and drops s_tready in the same clock.
`default_nettype none

module cubic_bezier_evaluator #(
  parameter int COORD_BITS      = cbe_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = cbe_pkg::PARAM_FRAC_BITS_DEF,
  localparam int T_W        = PARAM_FRAC_BITS + 1,
  localparam int S_TDATA_W  = ((T_W + 7) / 8) * 8,
  localparam int OUT_W      = 9 * COORD_BITS + 27,
  localparam int M_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input stream. s_tdata: param_t.
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [S_TDATA_W-1:0]           s_tdata,
  // Result stream. m_tdata from bit 0: pos_x, pos_y, pos_z, tan_x, tan_y,
  // tan_z, acc_x, acc_y, acc_z.
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [M_TDATA_W-1:0]                m_tdata,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cbe_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [cbe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cbe_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import cbe_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = PARAM_FRAC_BITS;
  localparam int REG_W = 3 * C;
  localparam int TS_W  = T_W + 1;           // t as a signed operand
  localparam int A_W   = C + 3;             // -P0 + 3P1 - 3P2 + P3
  localparam int B_W   = C + 4;             // 3(P0 - 2P1 + P2)
  localparam int CC_W  = C + 3;             // 3(P1 - P0)
  localparam int U_W   = A_W + TS_W;        // a*t
  localparam int H_W   = U_W + 1;           // a*t + b*2^F
  localparam int G_W   = U_W + 3;           // 3a*t + 2b*2^F
  localparam int VP_W  = H_W + TS_W;
  localparam int VT_W  = G_W + TS_W;
  localparam int P2_W  = VP_W + 1;          // position after second step
  localparam int TS2_W = VT_W + 1;          // rounded tangent sum
  localparam int LO_W  = P2_W / 2;          // split of the last multiplication
  localparam int HI_W  = P2_W - LO_W;
  localparam int PLO_W = LO_W + 1 + TS_W;
  localparam int PHI_W = HI_W + TS_W;
  localparam int PS_W  = 3 * F + C;         // low bits of the final sum
  localparam int POS_W = C;
  localparam int TAN_W = C + 3;
  localparam int ACC_W = C + 6;

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << F;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [REG_W-1:0]     ctrl_point [NUM_CTRL];
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_idx   = paddr[CFG_ADDR_W-1:3];
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = CFG_DATA_W'(ctrl_point[cfg_idx]);

  // Register writes at the access phase of a write transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CTRL; i++) begin
        ctrl_point[i] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_CTRL_POINT_0: ctrl_point[0] <= pwdata[REG_W-1:0];
        REG_CTRL_POINT_1: ctrl_point[1] <= pwdata[REG_W-1:0];
        REG_CTRL_POINT_2: ctrl_point[2] <= pwdata[REG_W-1:0];
        REG_CTRL_POINT_3: ctrl_point[3] <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances unless the output is stalled.
  // --------------------------------------------------------------------------
  logic adv;
  logic v0, v1, v2, v3, v4, v5, v6;

  assign adv      = ~m_tvalid | m_tready;
  assign s_tready = adv;
  assign m_tvalid = v6;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register, t saturated to 1.0.
  // --------------------------------------------------------------------------
  logic [T_W-1:0] t_in;
  logic [T_W-1:0] t0, t1, t2, t3, t4;

  assign t_in = s_tdata[T_W-1:0];

  // The parameter is carried along to every stage that multiplies by it.
  always_ff @(posedge clk) begin
    if (adv) begin
      t0 <= (t_in > T_ONE) ? T_ONE : t_in;
      t1 <= t0;
      t2 <= t1;
      t3 <= t2;
      t4 <= t3;
    end
  end

  logic signed [TS_W-1:0] t0s, t2s, t4s;
  assign t0s = $signed({1'b0, t0});
  assign t2s = $signed({1'b0, t2});
  assign t4s = $signed({1'b0, t4});

  // Per-axis result registers.
  logic signed [POS_W-1:0] pos_q [NUM_AXES];
  logic signed [TAN_W-1:0] tan_q [NUM_AXES];
  logic signed [ACC_W-1:0] acc_q [NUM_AXES];

  // --------------------------------------------------------------------------
  // One arithmetic lane per axis.
  // --------------------------------------------------------------------------
  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
    logic signed [C-1:0]     p0, p1, p2, p3;
    logic signed [A_W-1:0]   d12, a_next;
    logic signed [B_W-1:0]   e_sum, b_next;
    logic signed [CC_W-1:0]  f_dif, c_next;
    logic signed [A_W-1:0]   coef_a;
    logic signed [B_W-1:0]   coef_b;
    logic signed [CC_W-1:0]  coef_c;
    logic signed [C-1:0]     coef_d;

    logic signed [U_W-1:0]   u1;
    logic signed [H_W-1:0]   h2;
    logic signed [G_W-1:0]   g2;
    logic signed [G_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0] acc2, acc3, acc4, acc5;
    logic signed [VP_W-1:0]  vp3;
    logic signed [VT_W-1:0]  vt3;
    logic signed [P2_W-1:0]  pos2_4;
    logic signed [TS2_W-1:0] tan_sum;
    logic signed [TAN_W-1:0] tan4, tan5;
    logic signed [PLO_W-1:0] plo5;
    logic signed [PHI_W-1:0] phi5;
    logic signed [PS_W-1:0]  pos_sum;

    assign p0 = $signed(ctrl_point[0][ax*C +: C]);
    assign p1 = $signed(ctrl_point[1][ax*C +: C]);
    assign p2 = $signed(ctrl_point[2][ax*C +: C]);
    assign p3 = $signed(ctrl_point[3][ax*C +: C]);

    // Power-basis coefficients: B(t) = a t^3 + b t^2 + c t + d.
    always_comb begin
      d12    = A_W'(p1) - A_W'(p2);
      a_next = A_W'(p3) - A_W'(p0) + d12 + (d12 <<< 1);
      e_sum  = B_W'(p0) + B_W'(p2) - (B_W'(p1) <<< 1);
      b_next = e_sum + (e_sum <<< 1);
      f_dif  = CC_W'(p1) - CC_W'(p0);
      c_next = f_dif + (f_dif <<< 1);
    end

    // Coefficients are registered and follow the control points in the next clock.
    always_ff @(posedge clk) begin
      coef_a <= a_next;
      coef_b <= b_next;
      coef_c <= c_next;
      coef_d <= p0;
    end

    // Stage 2 sums; the second derivative is rounded here. Half of
    // 6a*t + 2b*2^F is summed, so the rounding constant is a quarter unit.
    always_comb begin
      acc_sum = G_W'(u1) + (G_W'(u1) <<< 1)
              + G_W'($signed({coef_b, 2'b01, {(F - 2){1'b0}}}));
      tan_sum = TS2_W'(vt3)
              + TS2_W'($signed({coef_c, 1'b1, {(2 * F - 1){1'b0}}}));
    end

    // Final position sum, kept to the bits that reach the output.
    always_comb begin
      pos_sum = (PS_W'(phi5) <<< LO_W) + PS_W'(plo5)
              + $signed({coef_d, 1'b1, {(3 * F - 1){1'b0}}});
    end

    // Horner pipeline: multiply and add stages alternate.
    always_ff @(posedge clk) begin
      if (adv) begin
        // Stage 1: a*t.
        u1     <= coef_a * t0s;
        // Stage 2: position and tangent inner terms.
        h2     <= H_W'(u1) + (H_W'(coef_b) <<< F);
        g2     <= G_W'(u1) + (G_W'(u1) <<< 1) + (G_W'(coef_b) <<< (F + 1));
        acc2   <= acc_sum[F - 1 +: ACC_W];
        // Stage 3: second multiplication by t.
        vp3    <= h2 * t2s;
        vt3    <= g2 * t2s;
        acc3   <= acc2;
        // Stage 4: add c*2^2F; the tangent is rounded here.
        pos2_4 <= P2_W'(vp3) + (P2_W'(coef_c) <<< (2 * F));
        tan4   <= tan_sum[2 * F +: TAN_W];
        acc4   <= acc3;
        // Stage 5: last multiplication as two partial products.
        plo5   <= $signed({1'b0, pos2_4[LO_W-1:0]}) * t4s;
        phi5   <= $signed(pos2_4[P2_W-1:LO_W]) * t4s;
        tan5   <= tan4;
        acc5   <= acc4;
        // Stage 6: output register.
        pos_q[ax] <= pos_sum[3 * F +: POS_W];
        tan_q[ax] <= tan5;
        acc_q[ax] <= acc5;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result packing, first field in the lowest bits.
  // --------------------------------------------------------------------------
  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      m_tdata[i * POS_W +: POS_W]                         = pos_q[i];
      m_tdata[3 * POS_W + i * TAN_W +: TAN_W]             = tan_q[i];
      m_tdata[3 * POS_W + 3 * TAN_W + i * ACC_W +: ACC_W] = acc_q[i];
    end
  end

endmodule : cubic_bezier_evaluator

`default_nettype wire

// File: sim/cbe_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// Cubic Bezier evaluator result checker
// Watches the configuration port and both streams of the evaluator. It keeps
// its own copy of the control points, computes the expected point, tangent
// and second derivative for every accepted parameter, and compares each
// result transaction field by field with the oldest expected sample.
// ============================================================================
module cbe_result_checker #(
  parameter int COORD_BITS      = cbe_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = cbe_pkg::PARAM_FRAC_BITS_DEF,
  localparam int T_W       = PARAM_FRAC_BITS + 1,
  localparam int S_TDATA_W = ((T_W + 7) / 8) * 8,
  localparam int OUT_W     = 9 * COORD_BITS + 27,
  localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // Parameter stream. s_tdata: param_t.
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [S_TDATA_W-1:0]           s_tdata,
  // Result stream. m_tdata from bit 0: pos_x, pos_y, pos_z, tan_x, tan_y,
  // tan_z, acc_x, acc_y, acc_z.
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [M_TDATA_W-1:0]           m_tdata,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cbe_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             outstanding,
  output int                             mismatches
);

  localparam int TAN_W   = COORD_BITS + 3;
  localparam int ACC_W   = COORD_BITS + 6;
  localparam int TAN_LSB = 3 * COORD_BITS;
  localparam int ACC_LSB = TAN_LSB + 3 * TAN_W;
  localparam int T_ONE   = 1 << PARAM_FRAC_BITS;
  localparam int MAX_PRINTED = 100;

  logic [3*COORD_BITS-1:0] ctrl_pts [cbe_pkg::NUM_CTRL];
  logic [OUT_W-1:0]        expected_samples [$];
  logic [OUT_W-1:0]        oldest_sample;
  string                   axis_tag [3] = '{"x", "y", "z"};
  int                      err_count = 0;
  int                      queued = 0;

  assign outstanding = queued;
  assign mismatches  = err_count;

  // Prints one line per problem (up to a cap) and counts every one.
  task automatic report_error(input string msg);
    if (err_count < MAX_PRINTED) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    err_count++;
  endtask

  // Divides by 2^k, rounding to nearest with ties toward plus infinity.
  function automatic logic signed [127:0] round_units(input logic signed [127:0] num,
                                                      input int k);
    return (num + (128'sd1 <<< (k - 1))) >>> k;
  endfunction

  // Evaluates the curve, its tangent and its second derivative at one
  // parameter, exactly in wide integers, and packs the rounded fields.
  function automatic logic [OUT_W-1:0] eval_curve_sample(input logic [T_W-1:0] t_raw);
    logic signed [127:0] tt, ss, npos, ntan, nacc;
    logic signed [127:0] pc [4];
    logic [OUT_W-1:0]    sample;
    int                  ax;
    int                  i;
    sample = '0;
    // A parameter above one is clamped to exactly one.
    tt = (t_raw > T_ONE) ? T_ONE : t_raw;
    ss = T_ONE - tt;
    for (ax = 0; ax < 3; ax++) begin
      for (i = 0; i < 4; i++) begin
        pc[i] = $signed(ctrl_pts[i][COORD_BITS*ax +: COORD_BITS]);
      end
      npos = pc[0] * ss * ss * ss + 3 * pc[1] * ss * ss * tt
           + 3 * pc[2] * ss * tt * tt + pc[3] * tt * tt * tt;
      ntan = 3 * (pc[1] - pc[0]) * ss * ss + 6 * (pc[2] - pc[1]) * ss * tt
           + 3 * (pc[3] - pc[2]) * tt * tt;
      nacc = 6 * (pc[2] - 2 * pc[1] + pc[0]) * ss + 6 * (pc[3] - 2 * pc[2] + pc[1]) * tt;
      npos = round_units(npos, 3 * PARAM_FRAC_BITS);
      ntan = round_units(ntan, 2 * PARAM_FRAC_BITS);
      nacc = round_units(nacc, PARAM_FRAC_BITS);
      sample[COORD_BITS*ax +: COORD_BITS] = npos[COORD_BITS-1:0];
      sample[TAN_LSB + TAN_W*ax +: TAN_W] = ntan[TAN_W-1:0];
      sample[ACC_LSB + ACC_W*ax +: ACC_W] = nacc[ACC_W-1:0];
    end
    return sample;
  endfunction

  // Field-by-field comparison of one result with its expected sample.
  task automatic compare_sample(input logic [OUT_W-1:0] got, input logic [OUT_W-1:0] want);
    int ax;
    for (ax = 0; ax < 3; ax++) begin
      if (got[COORD_BITS*ax +: COORD_BITS] !== want[COORD_BITS*ax +: COORD_BITS]) begin
        report_error($sformatf("pos_%s got %0d, expected %0d", axis_tag[ax],
                     $signed(got[COORD_BITS*ax +: COORD_BITS]),
                     $signed(want[COORD_BITS*ax +: COORD_BITS])));
      end
      if (got[TAN_LSB + TAN_W*ax +: TAN_W] !== want[TAN_LSB + TAN_W*ax +: TAN_W]) begin
        report_error($sformatf("tan_%s got %0d, expected %0d", axis_tag[ax],
                     $signed(got[TAN_LSB + TAN_W*ax +: TAN_W]),
                     $signed(want[TAN_LSB + TAN_W*ax +: TAN_W])));
      end
      if (got[ACC_LSB + ACC_W*ax +: ACC_W] !== want[ACC_LSB + ACC_W*ax +: ACC_W]) begin
        report_error($sformatf("acc_%s got %0d, expected %0d", axis_tag[ax],
                     $signed(got[ACC_LSB + ACC_W*ax +: ACC_W]),
                     $signed(want[ACC_LSB + ACC_W*ax +: ACC_W])));
      end
    end
  endtask

  // Track register writes, predict on every input transaction and check
  // every output transaction.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbe_pkg::NUM_CTRL; i++) begin
        ctrl_pts[i] = '0;
      end
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        ctrl_pts[paddr[cbe_pkg::CFG_ADDR_W-1:3]] = pwdata[3*COORD_BITS-1:0];
      end
      if (s_tvalid && s_tready) begin
        expected_samples = {expected_samples, eval_curve_sample(s_tdata[T_W-1:0])};
      end
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          report_error("result transaction with no sample outstanding");
        end else begin
          oldest_sample = expected_samples.pop_front();
          compare_sample(m_tdata[OUT_W-1:0], oldest_sample);
        end
      end
    end
    queued = expected_samples.size();
  end

endmodule

// File: sim/tb_cubic_bezier_evaluator.sv
`timescale 1ns / 100ps
// ============================================================================
// Cubic Bezier evaluator testbench
// Loads a series of control point sets through the configuration port and
// streams parameters into the evaluator with bursty input and a stalling
// output side. Corner parameters come first, then random ones; the result
// checker predicts and compares every result.
// ============================================================================
module tb_cubic_bezier_evaluator;

  localparam int COORD_BITS      = cbe_pkg::COORD_BITS_DEF;
  localparam int PARAM_FRAC_BITS = cbe_pkg::PARAM_FRAC_BITS_DEF;
  localparam int T_W             = PARAM_FRAC_BITS + 1;
  localparam int S_TDATA_W       = ((T_W + 7) / 8) * 8;
  localparam int OUT_W           = 9 * COORD_BITS + 27;
  localparam int M_TDATA_W       = ((OUT_W + 7) / 8) * 8;
  localparam int T_ONE           = 1 << PARAM_FRAC_BITS;
  localparam int DRAIN_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int NUM_RAND_SETS   = 8;
  localparam int PARAMS_PER_SET  = 219;

  localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [S_TDATA_W-1:0]           s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [M_TDATA_W-1:0]           m_tdata;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [cbe_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [cbe_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [cbe_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  int outstanding;
  int mismatches;
  int cycle_count = 0;
  int burst_left = 0;
  int ready_mode = 0;
  int ready_left = 0;

  logic [T_W-1:0] corner_params [12] = '{
    16'h0000, 16'h0001, 16'h2000, 16'h3FFF, 16'h4000, 16'h4001,
    16'h5555, 16'h7FFF, 16'h8000, 16'h8001, 16'hAAAA, 16'hFFFF
  };

  cubic_bezier_evaluator #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  cbe_result_checker #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cubic_bezier_evaluator test failed");
      $finish;
    end
  end

  // Output side backpressure: stretches of always ready, random stalls,
  // rare stalls and heavy stalls.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(20, 150);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_tready <= ($urandom_range(0, 7) != 0);
      end
      default: begin
        m_tready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // One configuration write: setup cycle, then access until pready.
  task automatic apb_write(input logic [cbe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cbe_pkg::CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all four control points, then lets the derived coefficients settle.
  task automatic load_curve(input logic [63:0] p0, input logic [63:0] p1,
                            input logic [63:0] p2, input logic [63:0] p3);
    apb_write(cbe_pkg::REG_CTRL_POINT_0, p0);
    apb_write(cbe_pkg::REG_CTRL_POINT_1, p1);
    apb_write(cbe_pkg::REG_CTRL_POINT_2, p2);
    apb_write(cbe_pkg::REG_CTRL_POINT_3, p3);
    repeat (3) @(posedge clk);
  endtask

  // Packs one point; the unused upper bits carry junk that must be dropped.
  function automatic logic [63:0] pack_point(input logic [COORD_BITS-1:0] x,
                                             input logic [COORD_BITS-1:0] y,
                                             input logic [COORD_BITS-1:0] z);
    logic [63:0] word;
    word = {$urandom, $urandom};
    word[3*COORD_BITS-1:0] = {z, y, x};
    return word;
  endfunction

  // Coordinates of moderate size, for curves that stay well inside range.
  function automatic logic [63:0] modest_point();
    return pack_point(COORD_BITS'($urandom_range(0, 4095) - 2048),
                      COORD_BITS'($urandom_range(0, 4095) - 2048),
                      COORD_BITS'($urandom_range(0, 4095) - 2048));
  endfunction

  // Mostly in-range parameters, with edges and values above one mixed in.
  function automatic logic [T_W-1:0] random_param();
    logic [T_W-1:0] t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        t = T_W'($urandom_range(0, T_ONE));
      end
      6: begin
        t = T_W'(T_ONE - $urandom_range(0, 1) + $urandom_range(0, 1) * 0);
        if ($urandom_range(0, 1) == 1) begin
          t = T_W'($urandom_range(0, 1));
        end
      end
      default: begin
        t = T_W'($urandom);
      end
    endcase
    return t;
  endfunction

  // Sends one parameter transaction; ends bursts with random gaps.
  task automatic send_param(input logic [T_W-1:0] t);
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(t);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 24);
    end
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Main sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Corner parameters with the reset control points (all zero).
    foreach (corner_params[i]) send_param(corner_params[i]);
    drain_results();

    // Corner parameters on the steepest possible curve.
    load_curve(pack_point(COORD_MIN, COORD_MAX, COORD_MIN),
               pack_point(COORD_MAX, COORD_MIN, COORD_MAX),
               pack_point(COORD_MIN, COORD_MAX, COORD_MIN),
               pack_point(COORD_MAX, COORD_MIN, COORD_MAX));
    foreach (corner_params[i]) send_param(corner_params[i]);
    drain_results();

    // Random parameters over a series of control point sets.
    for (int set_idx = 0; set_idx < NUM_RAND_SETS; set_idx++) begin
      case (set_idx)
        0: begin
          load_curve(pack_point(COORD_MAX, COORD_MAX, COORD_MIN),
                     pack_point(COORD_MIN, COORD_MIN, COORD_MAX),
                     pack_point(COORD_MAX, COORD_MAX, COORD_MIN),
                     pack_point(COORD_MIN, COORD_MIN, COORD_MAX));
        end
        1: begin
          load_curve(pack_point(COORD_MAX, COORD_MAX, COORD_MAX),
                     pack_point(COORD_MAX, COORD_MAX, COORD_MAX),
                     pack_point(COORD_MAX, COORD_MAX, COORD_MAX),
                     pack_point(COORD_MAX, COORD_MAX, COORD_MAX));
        end
        2: begin
          load_curve(pack_point(COORD_MIN, COORD_MIN, COORD_MIN),
                     pack_point(COORD_MIN, COORD_MIN, COORD_MIN),
                     pack_point(COORD_MIN, COORD_MIN, COORD_MIN),
                     pack_point(COORD_MIN, COORD_MIN, COORD_MIN));
        end
        4, 6: begin
          load_curve(modest_point(), modest_point(), modest_point(), modest_point());
        end
        default: begin
          load_curve({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
        end
      endcase
      for (int n = 0; n < PARAMS_PER_SET; n++) begin
        // Once, let the whole pipeline empty in the middle of a stream.
        if (set_idx == 3 && n == PARAMS_PER_SET / 2) begin
          drain_results();
        end
        send_param(random_param());
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("cubic_bezier_evaluator test passed");
    end else begin
      $display("cubic_bezier_evaluator test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cbe_pkg.sv
rtl/cubic_bezier_evaluator.sv
sim/cbe_result_checker.sv
sim/tb_cubic_bezier_evaluator.sv
